/* rtl/gbba_pkg.sv */
// Shared types, constants and codes for the grouped bitmap block allocator.
// No dependencies; every other file in rtl/ imports this package.
package gbba_pkg;

   localparam int MAX_GROUPS_DEF = 8;
   localparam int GROUP_BITS_DEF = 8192;

   localparam int WORD_W     = 64;
   localparam int WORD_SH    = 6;
   localparam int BPG_W      = 14;
   localparam int GC_W       = 4;
   localparam int CAP_W      = 18;
   localparam int BLK_W      = 17;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [BPG_W-1:0] BPG_RESET = 14'd8192;
   localparam logic [GC_W-1:0]  GC_RESET  = 4'd8;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BPG    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUPS = 8'd1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_INVALID  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GCHK,
      ST_ARD,
      ST_ATST,
      ST_FDIV,
      ST_FRD,
      ST_FTST,
      ST_DONE
   } state_type;

   // effective configuration, already saturated
   typedef struct packed {
      logic [BPG_W-1:0] bpg;
      logic [GC_W-1:0]  groups;
      logic [CAP_W-1:0] cap;
   } cfg_type;

   typedef struct packed {
      status_type       status;
      logic [BLK_W-1:0] granted;
      logic [BLK_W-1:0] free_total;
   } result_type;

endpackage

/* rtl/gbba_bitmap_ram.sv */
// Single-port synchronous bitmap store, one 64-bit word per address.
// Registered read data. Uses gbba_pkg.
module gbba_bitmap_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic                      re,
   input  logic [ADDR_W-1:0]         addr,
   input  logic [gbba_pkg::WORD_W-1:0] wdata,
   output logic [gbba_pkg::WORD_W-1:0] rdata
);
   import gbba_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/gbba_word_scan.sv */
// Lowest-clear-bit search over one bitmap word, limited to the low fill bits.
// Gives hit flag, one-hot pick and bit position. Uses gbba_pkg.
module gbba_word_scan (
   input  logic [gbba_pkg::WORD_W-1:0] word,
   input  logic [gbba_pkg::WORD_SH:0]  fill,
   output logic                        hit,
   output logic [gbba_pkg::WORD_W-1:0] pick,
   output logic [gbba_pkg::WORD_SH-1:0] pos
);
   import gbba_pkg::*;

   logic [WORD_W-1:0] vmask;
   logic [WORD_W-1:0] clear;

   always_comb begin
      if (fill[WORD_SH]) begin
         vmask = '1;
      end else begin
         vmask = (WORD_W'(1) << fill[WORD_SH-1:0]) - WORD_W'(1);
      end
      clear = ~word & vmask;
      pick  = clear & (~clear + WORD_W'(1));
      hit   = |clear;
      pos   = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (pick[i]) begin
            pos = pos | WORD_SH'(i);
         end
      end
   end

endmodule

/* rtl/gbba_ctrl.sv */
// Allocator sequencer: clearing pass, group scan, free split and bitmap update.
// Owns group counts and total; drives gbba_bitmap_ram and gbba_word_scan.
module gbba_ctrl #(
   parameter int MAX_GROUPS = gbba_pkg::MAX_GROUPS_DEF,
   parameter int GROUP_BITS = gbba_pkg::GROUP_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gbba_pkg::cfg_type          cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [gbba_pkg::BLK_W-1:0] req_num,
   output logic                       res_valid,
   input  logic                       res_ready,
   output gbba_pkg::result_type       res
);
   import gbba_pkg::*;

   localparam int WPG    = GROUP_BITS / WORD_W;
   localparam int DEPTH  = MAX_GROUPS * WPG;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int GRP_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int GCNT_W = $clog2(MAX_GROUPS + 1);
   localparam int CMP_W  = (GCNT_W > GC_W) ? GCNT_W : GC_W;

   state_type          state_ff, state_in;
   logic [GCNT_W-1:0]  grp_ff, grp_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BLK_W-1:0]   rem_ff, rem_in;
   logic [BPG_W-1:0]   boff_ff, boff_in;
   logic [CAP_W-1:0]   gbase_ff, gbase_in;
   logic [WORD_SH-1:0] bitk_ff, bitk_in;
   status_type         status_ff, status_in;
   logic               grant_ff, grant_in;
   logic [CAP_W-1:0]   total_ff, total_in;
   logic [BPG_W-1:0]   used_ff [MAX_GROUPS];
   logic [BPG_W-1:0]   used_in [MAX_GROUPS];

   logic               mem_we;
   logic               mem_re;
   logic [WORD_W-1:0]  mem_wdata;
   logic [WORD_W-1:0]  mem_rdata;
   logic [WORD_SH:0]   fill;
   logic               hit;
   logic [WORD_W-1:0]  pick;
   logic [WORD_SH-1:0] pos;

   logic [GRP_W-1:0]   grp_idx;
   logic               groups_done;
   logic [BLK_W-1:0]   num_m1;
   logic               range_bad;
   logic [WORD_W-1:0]  free_bit;

   gbba_bitmap_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (addr_ff),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   gbba_word_scan u_scan (
      .word (mem_rdata),
      .fill (fill),
      .hit  (hit),
      .pick (pick),
      .pos  (pos)
   );

   assign grp_idx     = grp_ff[GRP_W-1:0];
   assign groups_done = CMP_W'(grp_ff) >= CMP_W'(cfg.groups);
   assign num_m1      = req_num - BLK_W'(1);
   assign range_bad   = (req_num == '0) || (CAP_W'(num_m1) >= cfg.cap);
   assign fill        = (rem_ff >= BLK_W'(WORD_W)) ? (WORD_SH + 1)'(WORD_W)
                                                   : (WORD_SH + 1)'(rem_ff);
   assign free_bit    = WORD_W'(1) << rem_ff[WORD_SH-1:0];

   always_comb begin
      state_in  = state_ff;
      grp_in    = grp_ff;
      base_in   = base_ff;
      addr_in   = addr_ff;
      rem_in    = rem_ff;
      boff_in   = boff_ff;
      gbase_in  = gbase_ff;
      bitk_in   = bitk_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      total_in  = total_ff;
      used_in   = used_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wdata = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               grp_in   = '0;
               base_in  = '0;
               gbase_in = '0;
               grant_in = 1'b0;
               if (req_op == OP_ALLOC) begin
                  state_in = ST_GCHK;
               end else if (range_bad) begin
                  status_in = STATUS_INVALID;
                  state_in  = ST_DONE;
               end else begin
                  rem_in   = num_m1;
                  state_in = ST_FDIV;
               end
            end
         end
         ST_GCHK: begin
            if (groups_done) begin
               status_in = STATUS_NO_SPACE;
               state_in  = ST_DONE;
            end else if (used_ff[grp_idx] >= cfg.bpg) begin
               grp_in   = grp_ff + GCNT_W'(1);
               base_in  = base_ff + ADDR_W'(WPG);
               gbase_in = gbase_ff + CAP_W'(cfg.bpg);
            end else begin
               addr_in  = base_ff;
               rem_in   = BLK_W'(cfg.bpg);
               boff_in  = '0;
               state_in = ST_ARD;
            end
         end
         ST_ARD: begin
            mem_re   = 1'b1;
            state_in = ST_ATST;
         end
         ST_ATST: begin
            if (hit) begin
               mem_we           = 1'b1;
               mem_wdata        = mem_rdata | pick;
               used_in[grp_idx] = used_ff[grp_idx] + BPG_W'(1);
               total_in         = total_ff + CAP_W'(1);
               bitk_in          = pos;
               grant_in         = 1'b1;
               status_in        = STATUS_OK;
               state_in         = ST_DONE;
            end else if (rem_ff <= BLK_W'(WORD_W)) begin
               grp_in   = grp_ff + GCNT_W'(1);
               base_in  = base_ff + ADDR_W'(WPG);
               gbase_in = gbase_ff + CAP_W'(cfg.bpg);
               state_in = ST_GCHK;
            end else begin
               rem_in   = rem_ff - BLK_W'(WORD_W);
               boff_in  = boff_ff + BPG_W'(WORD_W);
               addr_in  = addr_ff + ADDR_W'(1);
               state_in = ST_ARD;
            end
         end
         ST_FDIV: begin
            if (rem_ff >= BLK_W'(cfg.bpg)) begin
               rem_in  = rem_ff - BLK_W'(cfg.bpg);
               grp_in  = grp_ff + GCNT_W'(1);
               base_in = base_ff + ADDR_W'(WPG);
            end else begin
               addr_in  = base_ff + ADDR_W'(rem_ff >> WORD_SH);
               state_in = ST_FRD;
            end
         end
         ST_FRD: begin
            mem_re   = 1'b1;
            state_in = ST_FTST;
         end
         ST_FTST: begin
            if ((mem_rdata & free_bit) != '0) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata & ~free_bit;
               if (used_ff[grp_idx] != '0) begin
                  used_in[grp_idx] = used_ff[grp_idx] - BPG_W'(1);
               end
               if (total_ff != '0) begin
                  total_in = total_ff - CAP_W'(1);
               end
               status_in = STATUS_OK;
            end else begin
               status_in = STATUS_INVALID;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status  = status_ff;
      res.granted = grant_ff ? BLK_W'(gbase_ff + CAP_W'(boff_ff) + CAP_W'(bitk_ff)
                                      + CAP_W'(1))
                             : '0;
      res.free_total = (cfg.cap > total_ff) ? BLK_W'(cfg.cap - total_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         total_ff <= '0;
         for (int g = 0; g < MAX_GROUPS; g++) begin
            used_ff[g] <= '0;
         end
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         total_ff <= total_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff    <= grp_in;
      base_ff   <= base_in;
      rem_ff    <= rem_in;
      boff_ff   <= boff_in;
      gbase_ff  <= gbase_in;
      bitk_ff   <= bitk_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
   end

endmodule

/* rtl/grouped_bitmap_block_allocator_top.sv */
// Top level of the grouped bitmap block allocator: config registers,
// result output stage and assertions. Uses gbba_pkg and gbba_ctrl.
//
//   channel  ports                                      direction
//   req      req_tvalid req_tready req_tdata req_tuser  in  (alloc / free)
//   rsp      rsp_tvalid rsp_tready rsp_tdata rsp_tuser  out (one per request)
//   csr      csr_valid csr_ready csr_index csr_data     in  (register write)
//
// One request at a time. Allocate checks each group's count, skipping full
// groups, then reads and tests bitmap words in turn (single RAM port, read
// then test/write). Free steps over whole groups when splitting the number,
// then reads, tests and clears the bit; a free of zero or past the capacity fails without a read.
// After reset a clearing pass writes MAX_GROUPS*GROUP_BITS/64 words (1024 at
// defaults) before req_tready rises. A stalled rsp holds the next result in
// the sequencer; a new request is taken while the output stage is full.
module grouped_bitmap_block_allocator_top #(
   parameter int MAX_GROUPS = gbba_pkg::MAX_GROUPS_DEF,
   parameter int GROUP_BITS = gbba_pkg::GROUP_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gbba_pkg::REQ_DATA_W-1:0] req_tdata,  // block_number[16:0]
   input  logic                            req_tuser,  // opcode[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gbba_pkg::RSP_DATA_W-1:0] rsp_tdata,  // granted_block[16:0], free_total[33:17]
   output logic [1:0]                      rsp_tuser,  // status[1:0]
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gbba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbba_pkg::CSR_DATA_W-1:0] csr_data
);
   import gbba_pkg::*;

   logic [BPG_W-1:0] bpg_ff;
   logic [GC_W-1:0]  gc_ff;
   cfg_type          cfg;

   logic             res_valid;
   logic             res_ready;
   result_type       res;
   logic             rsp_valid_ff;
   result_type       rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpg_ff <= BPG_RESET;
         gc_ff  <= GC_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BPG:    bpg_ff <= csr_data[BPG_W-1:0];
            CSR_GROUPS: gc_ff  <= csr_data[GC_W-1:0];
            default:    ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      if (bpg_ff == '0) begin
         cfg.bpg = BPG_W'(1);
      end else if (32'(bpg_ff) > GROUP_BITS) begin
         cfg.bpg = BPG_W'(GROUP_BITS);
      end else begin
         cfg.bpg = bpg_ff;
      end
      if (32'(gc_ff) > MAX_GROUPS) begin
         cfg.groups = GC_W'(MAX_GROUPS);
      end else begin
         cfg.groups = gc_ff;
      end
      cfg.cap = CAP_W'(cfg.groups) * CAP_W'(cfg.bpg);
   end

   gbba_ctrl #(
      .MAX_GROUPS (MAX_GROUPS),
      .GROUP_BITS (GROUP_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_num   (req_tdata[BLK_W-1:0]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {(RSP_DATA_W - 2 * BLK_W)'(0), rsp_ff.free_total, rsp_ff.granted};

`ifndef ASSERT_OFF
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_ff.status != STATUS_OK) |-> rsp_ff.granted == '0)
      else $error("granted block on a failed transfer");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid)
      else $error("result dropped while output stage full");
`endif

endmodule

/* tb/grouped_bitmap_block_allocator_top_tb.sv */
// Self-checking testbench for grouped_bitmap_block_allocator_top: a directed script
// followed by random phases, each result checked against scripted values or a local first-fit predictor.
// Depends on gbba_pkg and the RTL under rtl/ only.
`timescale 1ns / 100ps

module grouped_bitmap_block_allocator_top_tb;
   import gbba_pkg::*;

   localparam int NGROUPS      = MAX_GROUPS_DEF;
   localparam int NBITS        = GROUP_BITS_DEF;
   localparam int ITEM_TARGET  = 1650;
   localparam int IDLE_LIMIT   = 20000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   typedef enum bit {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic             op;
      logic [BLK_W-1:0] num;
      logic [7:0]       idx;
      logic [15:0]      val;
      bit               fixed;
      result_type       outcome;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_ALLOC;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   bit [NBITS-1:0]   used_map [NGROUPS];
   int unsigned      group_fill [NGROUPS];
   int unsigned      blocks_taken = 0;
   logic [BPG_W-1:0] bpg_reg = BPG_RESET;
   logic [GC_W-1:0]  gc_reg = GC_RESET;
   int unsigned      held_blocks [$];

   result_type       pending_outcomes [$];
   script_row_type   script_q [$];
   bit               row_fixed = 1'b0;
   result_type       row_outcome = '0;

   int unsigned requests_sent = 0;
   int unsigned outcomes_seen = 0;
   int unsigned errors = 0;
   int unsigned idle_cycles = 0;
   bit          moved;
   result_type  want;
   result_type  got;

   bit          gaps_on = 1'b1;
   int unsigned hold_asks = 0;
   int unsigned hold_done = 0;
   int unsigned hold_left = 0;

   grouped_bitmap_block_allocator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // block_number[16:0]
      .req_tuser  (req_tuser),   // opcode[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // granted_block[16:0], free_total[33:17]
      .rsp_tuser  (rsp_tuser),   // status[1:0]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned eff_bpg();
      int unsigned v;
      v = 32'(bpg_reg);
      if (v == 0) v = 1;
      if (v > NBITS) v = NBITS;
      return v;
   endfunction

   function automatic int unsigned eff_groups();
      int unsigned v;
      v = 32'(gc_reg);
      if (v > NGROUPS) v = NGROUPS;
      return v;
   endfunction

   // first-fit allocate or free, updating the local copy of the bitmap
   function automatic result_type apply_request(logic op, logic [BLK_W-1:0] num);
      result_type  r;
      int unsigned bpg, gcnt, cap, g, b, fg, fb, k, nv;
      bit          found;
      bpg = eff_bpg();
      gcnt = eff_groups();
      cap = gcnt * bpg;
      nv = 32'(num);
      r.granted = '0;
      found = 1'b0;
      fg = 0;
      fb = 0;
      if (op == OP_ALLOC) begin
         r.status = STATUS_NO_SPACE;
         for (g = 0; g < gcnt && !found; g++) begin
            if (group_fill[g] < bpg) begin
               for (b = 0; b < bpg && !found; b++) begin
                  if (!used_map[g][b]) begin
                     found = 1'b1;
                     fg = g;
                     fb = b;
                  end
               end
            end
         end
         if (found) begin
            used_map[fg][fb] = 1'b1;
            group_fill[fg]++;
            blocks_taken++;
            held_blocks.push_back(fg * NBITS + fb);
            r.granted = BLK_W'(fg * bpg + fb + 1);
            r.status = STATUS_OK;
         end
      end else begin
         r.status = STATUS_INVALID;
         if (nv != 0 && nv <= cap) begin
            g = (nv - 1) / bpg;
            b = (nv - 1) % bpg;
            if (used_map[g][b]) begin
               used_map[g][b] = 1'b0;
               if (group_fill[g] > 0) group_fill[g]--;
               if (blocks_taken > 0) blocks_taken--;
               for (k = 0; k < held_blocks.size(); k++) begin
                  if (held_blocks[k] == g * NBITS + b) begin
                     held_blocks.delete(k);
                     break;
                  end
               end
               r.status = STATUS_OK;
            end
         end
      end
      r.free_total = BLK_W'(cap > blocks_taken ? cap - blocks_taken : 0);
      return r;
   endfunction

   // transfers on all three channels, prediction, checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            outcomes_seen++;
            if (pending_outcomes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: status %0d granted %0d free %0d",
                           rsp_tuser, rsp_tdata[16:0], rsp_tdata[33:17]);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata[16:0] !== want.granted ||
                   rsp_tdata[33:17] !== want.free_total) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: status %0d/%0d granted %0d/%0d free %0d/%0d (exp/act)",
                              want.status, rsp_tuser, want.granted, rsp_tdata[16:0],
                              want.free_total, rsp_tdata[33:17]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            got = apply_request(req_tuser, req_tdata[BLK_W-1:0]);
            pending_outcomes.push_back(row_fixed ? row_outcome : got);
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            if (csr_index == CSR_BPG) bpg_reg = csr_data[BPG_W-1:0];
            else if (csr_index == CSR_GROUPS) gc_reg = csr_data[GC_W-1:0];
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // result side: random back-pressure plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= hold_done + 1;
      end else begin
         rsp_tready <= !gaps_on || $urandom_range(99) >= 21;
      end
   end

   task automatic send_req(logic op, logic [BLK_W-1:0] num, bit fixed, result_type outcome);
      while (gaps_on && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-BLK_W){1'b0}}, num};
      req_tuser <= op;
      row_fixed <= fixed;
      row_outcome <= outcome;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // only once every outstanding result is back
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      while (outcomes_seen != requests_sent) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_item(logic op, logic [BLK_W-1:0] num, bit fixed = 1'b0,
                           status_type st = STATUS_OK, int granted = 0, int free_cnt = 0);
      script_row_type row;
      row.kind = ROW_ITEM;
      row.op = op;
      row.num = num;
      row.idx = '0;
      row.val = '0;
      row.fixed = fixed;
      row.outcome.status = st;
      row.outcome.granted = BLK_W'(granted);
      row.outcome.free_total = BLK_W'(free_cnt);
      script_q.push_back(row);
   endtask

   task automatic add_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row.kind = ROW_REG;
      row.op = OP_ALLOC;
      row.num = '0;
      row.idx = idx;
      row.val = val;
      row.fixed = 1'b0;
      row.outcome = '0;
      script_q.push_back(row);
   endtask

   initial begin
      int unsigned    items, phase, phase_len, n, r, bpg, gcnt, cap, k, g, b;
      logic           op;
      logic [16:0]    num;
      logic [15:0]    pick;
      script_row_type row;

      // after reset: 8 groups of 8192, capacity 65536
      add_item(OP_ALLOC, 17'd131071, 1, STATUS_OK, 1, 65535);
      add_item(OP_ALLOC, 17'd0, 1, STATUS_OK, 2, 65534);
      add_item(OP_FREE, 17'd0, 1, STATUS_INVALID, 0, 65534);
      add_item(OP_FREE, 17'd65537, 1, STATUS_INVALID, 0, 65534);
      add_item(OP_FREE, 17'd131071, 1, STATUS_INVALID, 0, 65534);
      add_item(OP_FREE, 17'd65536, 1, STATUS_INVALID, 0, 65534);
      add_item(OP_FREE, 17'd1, 1, STATUS_OK, 0, 65535);
      add_item(OP_FREE, 17'd1, 1, STATUS_INVALID, 0, 65535);
      add_item(OP_ALLOC, 17'd65536, 1, STATUS_OK, 1, 65534);
      // no groups at all
      add_reg(CSR_GROUPS, 16'h0000);
      add_item(OP_ALLOC, 17'd0, 1, STATUS_NO_SPACE, 0, 0);
      add_item(OP_FREE, 17'd1, 1, STATUS_INVALID, 0, 0);
      // group count saturates, zero group size taken as one
      add_reg(CSR_GROUPS, 16'hFFFF);
      add_reg(CSR_BPG, 16'h0000);
      add_item(OP_ALLOC, 17'd0);
      add_item(OP_ALLOC, 17'd0);
      add_item(OP_FREE, 17'd2);
      // group size saturates to full width
      add_reg(CSR_BPG, 16'hFFFF);
      add_item(OP_FREE, 17'd8193);
      add_item(OP_FREE, 17'd65536);
      // shrink below what is already in use
      add_reg(CSR_BPG, 16'd2);
      add_reg(CSR_GROUPS, 16'd1);
      add_item(OP_ALLOC, 17'd0);
      add_item(OP_FREE, 17'd3);
      add_item(OP_FREE, 17'd2);
      add_item(OP_ALLOC, 17'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      items = 0;
      foreach (script_q[i]) begin
         row = script_q[i];
         if (row.kind == ROW_REG) begin
            write_reg(row.idx, row.val);
         end else begin
            send_req(row.op, row.num, row.fixed, row.outcome);
            items++;
         end
      end

      phase = 0;
      while (items < ITEM_TARGET) begin
         r = $urandom_range(99);
         if (r < 30) pick = 16'($urandom_range(1, 8));
         else if (r < 70) pick = 16'($urandom_range(9, 130));
         else if (r < 78) pick = 0;
         else if (r < 86) pick = 8192;
         else if (r < 91) pick = 16383;
         else pick = 16'($urandom_range(16383));
         pick[15:14] = 2'($urandom_range(3));
         if (phase == 0 || $urandom_range(99) < 80) write_reg(CSR_BPG, pick);
         r = $urandom_range(99);
         pick = 16'($urandom_range(65535));
         if (r < 12) pick[3:0] = 0;
         else if (r < 22) pick[3:0] = 4'($urandom_range(9, 15));
         else pick[3:0] = 4'($urandom_range(1, 8));
         if (phase == 0 || $urandom_range(99) < 80) write_reg(CSR_GROUPS, pick);
         if ($urandom_range(99) < 15)
            write_reg(CSR_IDX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom_range(65535)));

         gaps_on = !(phase == 2 || phase == 4);
         if (phase == 2) hold_asks++;

         bpg = eff_bpg();
         gcnt = eff_groups();
         cap = gcnt * bpg;
         phase_len = $urandom_range(40, 110);
         for (n = 0; n < phase_len && items < ITEM_TARGET; n++) begin
            r = $urandom_range(99);
            num = BLK_W'($urandom_range(131071));
            if (r < 50) begin
               op = OP_ALLOC;
            end else if (r < 88 && held_blocks.size() != 0) begin
               op = OP_FREE;
               k = $urandom_range(held_blocks.size() - 1);
               g = held_blocks[k] / NBITS;
               b = held_blocks[k] % NBITS;
               if (g < gcnt && b < bpg) num = BLK_W'(g * bpg + b + 1);
               else if (cap != 0) num = BLK_W'($urandom_range(1, cap));
            end else begin
               op = OP_FREE;
               r = $urandom_range(99);
               if (r < 15) num = 0;
               else if (r < 60 && cap != 0) num = BLK_W'($urandom_range(1, cap));
            end
            send_req(op, num, 1'b0, '0);
            items++;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      gaps_on = 1'b1;
      while (outcomes_seen < requests_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) errors++;
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
